[rtl/cfr_pkg.sv]
// shared types and constants for the checksum frame receiver
package cfr_pkg;

    localparam int BYTE_W = 8;
    localparam int SUM_W  = 16;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef enum logic [3:0] {
        PH_LEN  = 4'b0001,
        PH_DATA = 4'b0010,
        PH_CKLO = 4'b0100,
        PH_CKHI = 4'b1000
    } phase_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

endpackage

[rtl/cfr_if.sv]
// valid/ready channels for received bytes and parsed results
interface cfr_in_if;
    import cfr_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_out_if;
    import cfr_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    byte_t data_byte;
    byte_t byte_index;
    logic  checksum_ok;
    byte_t frame_length;

    modport source (output valid, output kind, output data_byte, output byte_index,
                    output checksum_ok, output frame_length, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_index,
                    input checksum_ok, input frame_length, output ready);
endinterface

[rtl/checksum_frame_receiver_top.sv]
// length-prefixed frame parser with 16-bit sum checksum check
// an accepted byte goes through the input register, then the result register
// one byte per cycle unless results stall; one more byte then waits in the input register
// length and checksum-low bytes produce no result
// reset: asynchronous active-low, returns to awaiting a length byte with all
// counters and the sum cleared, both registers empty
module checksum_frame_receiver_top (
    input  logic            clk,
    input  logic            rst_n,
    cfr_in_if.sink          rx,
    cfr_out_if.source       result
);
    import cfr_pkg::*;

    // input register
    logic   in_valid_reg;
    byte_t  in_byte_reg;

    // parser state
    phase_t phase_reg, phase_next;
    byte_t  remaining_reg, remaining_next;
    byte_t  position_reg, position_next;
    byte_t  length_reg, length_next;
    sum_t   sum_reg, sum_next;
    byte_t  ck_low_reg, ck_low_next;

    // result register
    logic   out_valid_reg;
    logic   kind_reg, kind_next;
    byte_t  data_reg, data_next;
    byte_t  index_reg, index_next;
    logic   ok_reg, ok_next;
    byte_t  flen_reg, flen_next;

    logic   emit;
    logic   consume;

    assign consume  = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready = !in_valid_reg || consume;

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        length_next    = length_reg;
        sum_next       = sum_reg;
        ck_low_next    = ck_low_reg;
        emit           = 1'b0;
        kind_next      = KIND_DATA;
        data_next      = '0;
        index_next     = '0;
        ok_next        = 1'b0;
        flen_next      = '0;
        case (phase_reg)
            PH_LEN:
            begin
                length_next    = in_byte_reg;
                remaining_next = in_byte_reg;
                position_next  = '0;
                sum_next       = '0;
                phase_next     = (in_byte_reg == '0) ? PH_CKLO : PH_DATA;
            end
            PH_DATA:
            begin
                emit           = 1'b1;
                kind_next      = KIND_DATA;
                data_next      = in_byte_reg;
                index_next     = position_reg;
                sum_next       = sum_reg + {{(SUM_W-BYTE_W){1'b0}}, in_byte_reg};
                position_next  = position_reg + 1'b1;
                remaining_next = remaining_reg - 1'b1;
                if (remaining_reg == byte_t'(1))
                begin
                    phase_next = PH_CKLO;
                end
            end
            PH_CKLO:
            begin
                ck_low_next = in_byte_reg;
                phase_next  = PH_CKHI;
            end
            PH_CKHI:
            begin
                emit       = 1'b1;
                kind_next  = KIND_STATUS;
                ok_next    = ({in_byte_reg, ck_low_reg} == sum_reg);
                flen_next  = length_reg;
                phase_next = PH_LEN;
            end
            default:
            begin
                phase_next = PH_LEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_LEN;
            remaining_reg <= '0;
            position_reg  <= '0;
            length_reg    <= '0;
            sum_reg       <= '0;
            ck_low_reg    <= '0;
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end

            if (consume)
            begin
                phase_reg     <= phase_next;
                remaining_reg <= remaining_next;
                position_reg  <= position_next;
                length_reg    <= length_next;
                sum_reg       <= sum_next;
                ck_low_reg    <= ck_low_next;
                out_valid_reg <= emit;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (consume && emit)
        begin
            kind_reg  <= kind_next;
            data_reg  <= data_next;
            index_reg <= index_next;
            ok_reg    <= ok_next;
            flen_reg  <= flen_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = kind_reg;
    assign result.data_byte    = data_reg;
    assign result.byte_index   = index_reg;
    assign result.checksum_ok  = ok_reg;
    assign result.frame_length = flen_reg;

endmodule

[tb/testbench.sv]
// self-checking testbench for the checksum frame receiver: frame stream, prediction and checks
`timescale 1ns / 1ps

module testbench;
    import cfr_pkg::*;

    typedef struct {
        kind_t kind;
        byte_t data_byte;
        byte_t byte_index;
        logic  checksum_ok;
        byte_t frame_length;
    } frame_result_t;

    // parses the accepted byte stream and holds the results the block owes
    class frame_checker;
        phase_t        parse_phase;
        byte_t         bytes_left;
        byte_t         next_index;
        byte_t         frame_len;
        sum_t          payload_sum;
        byte_t         ck_low;
        frame_result_t expected_results[$];
        int            errors;
        int            n_frames;
        int            n_payload;
        int            n_bad_sum;

        function new();
            parse_phase = PH_LEN;
            bytes_left  = '0;
            next_index  = '0;
            frame_len   = '0;
            payload_sum = '0;
            ck_low      = '0;
            errors      = 0;
            n_frames    = 0;
            n_payload   = 0;
            n_bad_sum   = 0;
        endfunction

        function void take_rx_byte(byte_t b);
            frame_result_t r;
            case (parse_phase)
                PH_LEN:
                begin
                    frame_len   = b;
                    bytes_left  = b;
                    next_index  = '0;
                    payload_sum = '0;
                    parse_phase = (b == 0) ? PH_CKLO : PH_DATA;
                end
                PH_DATA:
                begin
                    r = '{KIND_DATA, b, next_index, 1'b0, 8'h00};
                    expected_results.push_back(r);
                    payload_sum = payload_sum + sum_t'(b);
                    next_index  = next_index + 8'd1;
                    bytes_left  = bytes_left - 8'd1;
                    n_payload++;
                    if (bytes_left == 0)
                        parse_phase = PH_CKLO;
                end
                PH_CKLO:
                begin
                    ck_low      = b;
                    parse_phase = PH_CKHI;
                end
                default:
                begin
                    r = '{KIND_STATUS, 8'h00, 8'h00, ({b, ck_low} == payload_sum), frame_len};
                    expected_results.push_back(r);
                    n_frames++;
                    if (!r.checksum_ok)
                        n_bad_sum++;
                    parse_phase = PH_LEN;
                end
            endcase
        endfunction

        function void check_result(logic kind, byte_t data_byte, byte_t byte_index,
                                   logic checksum_ok, byte_t frame_length);
            frame_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: kind %0d data %0h", kind, data_byte);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (kind !== e.kind)
            begin
                $error("kind: expected %0d, actual %0d", e.kind, kind);
                errors++;
            end
            if (data_byte !== e.data_byte)
            begin
                $error("data_byte: expected %0h, actual %0h", e.data_byte, data_byte);
                errors++;
            end
            if (byte_index !== e.byte_index)
            begin
                $error("byte_index: expected %0d, actual %0d", e.byte_index, byte_index);
                errors++;
            end
            if (checksum_ok !== e.checksum_ok)
            begin
                $error("checksum_ok: expected %0d, actual %0d", e.checksum_ok, checksum_ok);
                errors++;
            end
            if (frame_length !== e.frame_length)
            begin
                $error("frame_length: expected %0d, actual %0d", e.frame_length, frame_length);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cfr_in_if  rx_if ();
    cfr_out_if res_if ();

    checksum_frame_receiver_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_if.sink),
        .result (res_if.source)
    );

    frame_checker sb;
    byte_t        rx_stream[$];
    int           n_accepted;
    bit           quiet;
    bit           hold_done;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // frame = length, payload, checksum low byte, checksum high byte; flip corrupts the sum
    task automatic queue_frame(input byte_t payload[$], input sum_t flip);
        sum_t s;
        s = '0;
        rx_stream.push_back(byte_t'(payload.size()));
        foreach (payload[i])
        begin
            rx_stream.push_back(payload[i]);
            s = s + sum_t'(payload[i]);
        end
        s = s ^ flip;
        rx_stream.push_back(s[7:0]);
        rx_stream.push_back(s[15:8]);
    endtask

    task automatic queue_random_frame();
        byte_t pl[$];
        int    len;
        int    r;
        sum_t  flip;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = $urandom_range(0, 8);
        else if (r < 97)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(200, 255);
        for (int i = 0; i < len; i++)
            pl.push_back(byte_t'($urandom_range(0, 255)));
        flip = '0;
        r = $urandom_range(0, 99);
        if (r < 15)
            flip = sum_t'($urandom_range(1, 65535));
        else if (r < 25)
            flip = sum_t'(1) << $urandom_range(0, 15);
        queue_frame(pl, flip);
    endtask

    task automatic build_stream();
        byte_t pl[$];
        // empty frames, good and bad, then short good frames
        pl = {};
        queue_frame(pl, 16'h0000);
        queue_frame(pl, 16'h0100);
        pl = {8'h00};
        queue_frame(pl, 16'h0000);
        pl = {8'hFF, 8'h80};
        queue_frame(pl, 16'h0000);
        // wrong high byte, then wrong low byte
        pl = {8'h55, 8'hAA};
        queue_frame(pl, 16'h8000);
        pl = {8'h7F};
        queue_frame(pl, 16'h0001);
        // longest frame with the largest sum
        pl = {};
        for (int i = 0; i < 255; i++)
            pl.push_back(8'hFF);
        queue_frame(pl, 16'h0000);
        while (rx_stream.size() < 1000)
            queue_random_frame();
    endtask

    task automatic drive_stream();
        for (int i = 0; i < rx_stream.size(); i++)
        begin
            quiet = (i >= rx_stream.size() - 150);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rx_if.valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            rx_if.valid   <= 1'b1;
            rx_if.rx_byte <= rx_stream[i];
            @(posedge clk);
            while (!rx_if.ready)
                @(posedge clk);
        end
        rx_if.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rx_if.valid && rx_if.ready)
        begin
            sb.take_rx_byte(rx_if.rx_byte);
            n_accepted++;
        end
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.kind, res_if.data_byte, res_if.byte_index,
                            res_if.checksum_ok, res_if.frame_length);
    end

    // result side: short random stalls, one long hold-off mid run
    initial
    begin
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && n_accepted >= 400)
            begin
                hold_done = 1'b1;
                res_if.ready <= 1'b0;
                repeat (64) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    initial
    begin
        #3_000_000;
        $display("checksum_frame_receiver_top regression: fail");
        $finish;
    end

    initial
    begin
        sb          = new();
        n_accepted  = 0;
        quiet       = 1'b0;
        hold_done   = 1'b0;
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        build_stream();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_stream();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("sent %0d bytes: %0d frames closed, %0d payload bytes, %0d bad checksums",
                 n_accepted, sb.n_frames, sb.n_payload, sb.n_bad_sum);
        $display("included empty and 255-byte frames, random stalls and one long result hold-off");
        if (sb.errors == 0)
            $display("checksum_frame_receiver_top regression: pass");
        else
            $display("checksum_frame_receiver_top regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/cfr_pkg.sv
rtl/cfr_if.sv
rtl/checksum_frame_receiver_top.sv
tb/testbench.sv
